// ===== hw/rtl/tcr_pkg.sv =====
package tcr_pkg;

    localparam int GLYPH_COLUMNS_DEF = 5;
    localparam int FONT_BYTES = 5;
    localparam int CELL_ROWS = 8;
    localparam int COORD_MAX = 32767;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN = 8'd13;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TEXT_SIZE    = 3'd0,
        REG_TEXT_COLOR   = 3'd1,
        REG_BACK_COLOR   = 3'd2,
        REG_WRAP_ENABLE  = 3'd3,
        REG_PANEL_WIDTH  = 3'd4,
        REG_PANEL_HEIGHT = 3'd5
    } reg_idx_t;

    // Datapath action selected by a control word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_WRAP,
        OP_SETUP,
        OP_SCAN,
        OP_BACK,
        OP_FINISH,
        OP_NEWLINE
    } op_t;

    // Jump condition of a control word.
    typedef enum logic [2:0] {
        CC_NEXT,
        CC_ALWAYS,
        CC_NO_INPUT,
        CC_NEWLINE,
        CC_RETURN,
        CC_DROP,
        CC_SCAN_MORE
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE    = 4'd0;
    localparam step_t ST_TEST_NL = 4'd1;
    localparam step_t ST_TEST_CR = 4'd2;
    localparam step_t ST_WRAP    = 4'd3;
    localparam step_t ST_SETUP   = 4'd4;
    localparam step_t ST_SCAN    = 4'd5;
    localparam step_t ST_BACK    = 4'd6;
    localparam step_t ST_FINISH  = 4'd7;
    localparam step_t ST_NEWLINE = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic        block_valid;
        logic [14:0] block_x;
        logic [14:0] block_y;
        logic [7:0]  block_w;
        logic [10:0] block_h;
        logic [15:0] block_color;
        logic        wrapped;
        logic        clipped;
        logic        last;
    } result_t;

    // Microprogram.
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        unique case (step)
            ST_IDLE:    w = '{op: OP_ACCEPT,  cond: CC_NO_INPUT,  target: ST_IDLE};
            ST_TEST_NL: w = '{op: OP_NONE,    cond: CC_NEWLINE,   target: ST_NEWLINE};
            ST_TEST_CR: w = '{op: OP_NONE,    cond: CC_RETURN,    target: ST_FINISH};
            ST_WRAP:    w = '{op: OP_WRAP,    cond: CC_NEXT,      target: ST_IDLE};
            ST_SETUP:   w = '{op: OP_SETUP,   cond: CC_DROP,      target: ST_FINISH};
            ST_SCAN:    w = '{op: OP_SCAN,    cond: CC_SCAN_MORE, target: ST_SCAN};
            ST_BACK:    w = '{op: OP_BACK,    cond: CC_NEXT,      target: ST_IDLE};
            ST_FINISH:  w = '{op: OP_FINISH,  cond: CC_ALWAYS,    target: ST_IDLE};
            ST_NEWLINE: w = '{op: OP_NEWLINE, cond: CC_ALWAYS,    target: ST_FINISH};
            default:    w = '{op: OP_NONE,    cond: CC_ALWAYS,    target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/text_cell_rasterizer.sv =====
// A drawn character passes through the test, wrap, setup, scan, back and finish steps;
// the scan and back steps can wait on a stalled output, and so can the finish step.
// Newline passes through the newline step to finish; carriage return and a dropped cell jump to finish.
// Characters are taken one at a time; the next is taken in the idle step that follows the
// loading of the last result word. The scan step visits one glyph bit per cycle unless a stalled output holds it.
// Reset (rst_n low, asynchronous) puts the cursor at 0,0 and the registers at their defaults.
module text_cell_rasterizer #(
    parameter int GLYPH_COLUMNS = tcr_pkg::GLYPH_COLUMNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Character input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic [39:0] glyph_columns,

    // Fill block output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        block_valid,
    output logic [14:0] block_x,
    output logic [14:0] block_y,
    output logic [7:0]  block_w,
    output logic [10:0] block_h,
    output logic [15:0] block_color,
    output logic        wrapped,
    output logic        clipped,
    output logic        last,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // The cell is the glyph columns plus one background column.
    localparam int CELL_COLS = GLYPH_COLUMNS + 1;
    localparam int IW = $clog2(GLYPH_COLUMNS);
    localparam int BW = IW + 3;

    // Configuration registers.
    logic [7:0]  text_size_reg;
    logic [15:0] text_color_reg;
    logic [15:0] back_color_reg;
    logic        wrap_en_reg;
    logic [10:0] panel_w_reg;
    logic [10:0] panel_h_reg;

    // Cursor and sequencer control state.
    logic [14:0]          cursor_col_reg, cursor_col_next;
    logic [14:0]          cursor_row_reg, cursor_row_next;
    tcr_pkg::step_t       step_reg, step_next;
    logic                 wrap_flag_reg, wrap_flag_next;
    logic                 clip_flag_reg, clip_flag_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        col_idx_reg, col_idx_next;
    logic [2:0]           row_idx_reg, row_idx_next;

    // Datapath payload registers.
    logic [7:0]           char_reg;
    logic [39:0]          glyph_reg;
    logic [14:0]          base_y_reg;
    logic [14:0]          cx_reg, cx_next;
    logic [14:0]          cy_reg, cy_next;
    tcr_pkg::result_t     pend_reg, pend_next;
    tcr_pkg::result_t     out_reg, out_next;

    tcr_pkg::ctrl_word_t  cw;
    logic                 cond_true;
    logic                 hold;
    logic                 out_free;

    logic [7:0]           scale;
    logic [11:0]          cell_w;
    logic [10:0]          cell_h;
    logic                 transparent;
    logic [15:0]          col_sum;
    logic [15:0]          row_sum;
    logic [14:0]          col_sat;
    logic [14:0]          row_sat;
    logic                 wrap_hit;
    logic                 drop;
    logic                 cut;
    logic                 col_fits;
    logic                 row_fits;
    logic [BW-1:0]        bit_idx;
    logic                 glyph_bit;
    logic                 scan_last;
    logic                 cand;
    tcr_pkg::result_t     cand_res;
    logic [10:0]          room_h;
    logic [10:0]          back_h;

    assign cfg_ready = 1'b1;
    assign in_stall  = (step_reg != tcr_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Cell geometry. A scale of zero behaves as one.
    always_comb
    begin
        scale       = (text_size_reg == 8'd0) ? 8'd1 : text_size_reg;
        cell_w      = 12'(scale * CELL_COLS);
        cell_h      = {scale, 3'b000};
        transparent = (text_color_reg == back_color_reg);

        col_sum  = {1'b0, cursor_col_reg} + 16'(cell_w);
        row_sum  = {1'b0, cursor_row_reg} + 16'(cell_h);
        col_sat  = (col_sum > 16'(tcr_pkg::COORD_MAX)) ? 15'(tcr_pkg::COORD_MAX)
                                                       : col_sum[14:0];
        row_sat  = (row_sum > 16'(tcr_pkg::COORD_MAX)) ? 15'(tcr_pkg::COORD_MAX)
                                                       : row_sum[14:0];
        wrap_hit = wrap_en_reg && (col_sum > 16'(panel_w_reg));
        drop     = (cursor_col_reg >= 15'(panel_w_reg)) || (cursor_row_reg >= 15'(panel_h_reg));
        cut      = (col_sum > 16'(panel_w_reg)) || (row_sum > 16'(panel_h_reg));

        // One glyph cell (or the background column) per cycle, unless a stalled output holds it.
        col_fits  = ({1'b0, cx_reg} + 16'(scale)) <= 16'(panel_w_reg);
        row_fits  = ({1'b0, cy_reg} + 16'(scale)) <= 16'(panel_h_reg);
        bit_idx   = {col_idx_reg, row_idx_reg};
        glyph_bit = (col_idx_reg < IW'(tcr_pkg::FONT_BYTES)) ? glyph_reg[bit_idx] : 1'b0;
        scan_last = (col_idx_reg == IW'(GLYPH_COLUMNS - 1)) && (row_idx_reg == 3'd7);

        // The cell is not dropped here, so the base row is below the panel height.
        room_h = panel_h_reg - base_y_reg[10:0];
        back_h = (room_h > cell_h) ? cell_h : room_h;

        cand_res.block_valid = 1'b1;
        cand_res.block_x     = cx_reg;
        cand_res.block_w     = scale;
        cand_res.wrapped     = wrap_flag_reg;
        cand_res.clipped     = clip_flag_reg;
        cand_res.last        = 1'b0;
        if (step_reg == tcr_pkg::ST_BACK)
        begin
            cand_res.block_y     = base_y_reg;
            cand_res.block_h     = back_h;
            cand_res.block_color = back_color_reg;
        end
        else
        begin
            cand_res.block_y     = cy_reg;
            cand_res.block_h     = 11'(scale);
            cand_res.block_color = glyph_bit ? text_color_reg : back_color_reg;
        end
    end

    // Sequencer: fetch the control word, decide hold and jump.
    always_comb
    begin
        cw = tcr_pkg::ucode(step_reg);

        unique case (cw.op)
            tcr_pkg::OP_SCAN: cand = col_fits && row_fits && (glyph_bit || !transparent);
            tcr_pkg::OP_BACK: cand = !transparent && col_fits;
            default:          cand = 1'b0;
        endcase

        // A new block can only replace the pending one if the previous word can move on.
        unique case (cw.op) inside
            tcr_pkg::OP_SCAN,
            tcr_pkg::OP_BACK:   hold = cand && pend_valid_reg && !out_free;
            tcr_pkg::OP_FINISH: hold = !out_free;
            default:            hold = 1'b0;
        endcase

        unique case (cw.cond)
            tcr_pkg::CC_NEXT:      cond_true = 1'b0;
            tcr_pkg::CC_ALWAYS:    cond_true = 1'b1;
            tcr_pkg::CC_NO_INPUT:  cond_true = !in_valid;
            tcr_pkg::CC_NEWLINE:   cond_true = (char_reg == tcr_pkg::CH_NEWLINE);
            tcr_pkg::CC_RETURN:    cond_true = (char_reg == tcr_pkg::CH_RETURN);
            tcr_pkg::CC_DROP:      cond_true = drop;
            tcr_pkg::CC_SCAN_MORE: cond_true = !scan_last;
            default:               cond_true = 1'b0;
        endcase

        if (hold)
            step_next = step_reg;
        else if (cond_true)
            step_next = cw.target;
        else
            step_next = step_reg + 4'd1;
    end

    // Datapath actions.
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        wrap_flag_next  = wrap_flag_reg;
        clip_flag_next  = clip_flag_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        col_idx_next    = col_idx_reg;
        row_idx_next    = row_idx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;

        unique case (cw.op) inside
            tcr_pkg::OP_ACCEPT:
            begin
                wrap_flag_next  = 1'b0;
                clip_flag_next  = 1'b0;
                pend_valid_next = 1'b0;
            end
            tcr_pkg::OP_WRAP:
            begin
                if (wrap_hit)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = row_sat;
                    wrap_flag_next  = 1'b1;
                end
            end
            tcr_pkg::OP_SETUP:
            begin
                clip_flag_next  = drop || cut;
                cursor_col_next = col_sat;
                cx_next         = cursor_col_reg;
                cy_next         = cursor_row_reg;
                col_idx_next    = '0;
                row_idx_next    = '0;
            end
            tcr_pkg::OP_SCAN,
            tcr_pkg::OP_BACK:
            begin
                if (!hold)
                begin
                    if (cand)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = cand_res;
                    end
                    if (cw.op == tcr_pkg::OP_SCAN)
                    begin
                        if (row_idx_reg == 3'd7)
                        begin
                            row_idx_next = '0;
                            col_idx_next = col_idx_reg + IW'(1);
                            cy_next      = base_y_reg;
                            cx_next      = cx_reg + 15'(scale);
                        end
                        else
                        begin
                            row_idx_next = row_idx_reg + 3'd1;
                            cy_next      = cy_reg + 15'(scale);
                        end
                    end
                end
            end
            tcr_pkg::OP_FINISH:
            begin
                if (!hold)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next         = '0;
                        out_next.wrapped = wrap_flag_reg;
                        out_next.clipped = clip_flag_reg;
                        out_next.last    = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            tcr_pkg::OP_NEWLINE:
            begin
                cursor_col_next = '0;
                cursor_row_next = row_sat;
            end
            default:
            begin
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= tcr_pkg::ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            wrap_flag_reg  <= 1'b0;
            clip_flag_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            col_idx_reg    <= '0;
            row_idx_reg    <= '0;
            text_size_reg  <= 8'd1;
            text_color_reg <= 16'hFFFF;
            back_color_reg <= 16'hFFFF;
            wrap_en_reg    <= 1'b1;
            panel_w_reg    <= 11'd368;
            panel_h_reg    <= 11'd448;
        end
        else
        begin
            step_reg       <= step_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            wrap_flag_reg  <= wrap_flag_next;
            clip_flag_reg  <= clip_flag_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            col_idx_reg    <= col_idx_next;
            row_idx_reg    <= row_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tcr_pkg::REG_TEXT_SIZE:    text_size_reg  <= cfg_data[7:0];
                    tcr_pkg::REG_TEXT_COLOR:   text_color_reg <= cfg_data;
                    tcr_pkg::REG_BACK_COLOR:   back_color_reg <= cfg_data;
                    tcr_pkg::REG_WRAP_ENABLE:  wrap_en_reg    <= cfg_data[0];
                    tcr_pkg::REG_PANEL_WIDTH:  panel_w_reg    <= cfg_data[10:0];
                    tcr_pkg::REG_PANEL_HEIGHT: panel_h_reg    <= cfg_data[10:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cw.op == tcr_pkg::OP_ACCEPT && in_valid)
        begin
            char_reg  <= char_code;
            glyph_reg <= glyph_columns;
        end
        if (cw.op == tcr_pkg::OP_SETUP)
            base_y_reg <= cursor_row_reg;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign block_valid = out_reg.block_valid;
    assign block_x     = out_reg.block_x;
    assign block_y     = out_reg.block_y;
    assign block_w     = out_reg.block_w;
    assign block_h     = out_reg.block_h;
    assign block_color = out_reg.block_color;
    assign wrapped     = out_reg.wrapped;
    assign clipped     = out_reg.clipped;
    assign last        = out_reg.last;

    // The finish step always drains the pending block before a new character comes in.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == tcr_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending block left over in idle");

    // An empty result word is always the only, and so the last, word of its character.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.block_valid) |-> out_reg.last)
        else $error("empty result word without last");

    // A drawn block never has zero size.
    a_block_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.block_valid) |->
        (out_reg.block_w != 8'd0 && out_reg.block_h != 11'd0))
        else $error("zero sized block");

    // Finishing with room at the output returns the sequencer to idle.
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == tcr_pkg::ST_FINISH && out_free) |=> (step_reg == tcr_pkg::ST_IDLE))
        else $error("finish step did not return to idle");

endmodule

// ===== dv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock period is 4 ns. Reset starts low and is released before the first stimulus.
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;

    // The longest quiet stretch in a correct run is the forced output hold below,
    // so the watchdog limit is set well above it.
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    // DRAIN_GAP pads each wait for idle; END_GAP is the tail wait after the final
    // owed word, to catch strays.
    localparam int DRAIN_GAP = 8;
    localparam int END_GAP = 64;

    localparam int NUM_PHASES = 6;
    localparam int PHASE_CHARS = 45;

    // Directed stimulus rows. A row either writes a register, sends a character
    // whose words come from the predictor, or sends a character whose single
    // empty word is known by inspection and typed in by its flags.
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_CHAR,
        ROW_EMPTY
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        tcr_pkg::reg_idx_t  idx;
        logic [15:0]        value;
        logic [7:0]         code;
        logic [39:0]        glyph;
        logic               wr;
        logic               cl;
    } dir_row_t;

    localparam int NUM_DIRECTED = 29;

    // The cursor walk through this table is planned: the comments give the cursor
    // (column, row) before each character.
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // Carriage return does nothing. (0,0)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, tcr_pkg::CH_RETURN, 40'h0, 1'b0, 1'b0},
        // Empty glyph while transparent leaves nothing visible. (0,0)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h41, 40'h0, 1'b0, 1'b0},
        // Highest code, all glyph bits set. (6,0)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'hFF, 40'hFF_FFFF_FFFF, 1'b0, 1'b0},
        // Lowest code is drawn like any other. (12,0)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h00, 40'h5A_3C_81_7E_A5, 1'b0, 1'b0},
        // Newline moves to (0,8).
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, tcr_pkg::CH_NEWLINE, 40'h0, 1'b0, 1'b0},
        // Opaque background from here on.
        '{ROW_REG, tcr_pkg::REG_BACK_COLOR, 16'h0000, 8'h0, 40'h0, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_TEXT_COLOR, 16'hF800, 8'h0, 40'h0, 1'b0, 1'b0},
        // All background: the full 41 words. (0,8)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h20, 40'h0, 1'b0, 1'b0},
        // All foreground plus the background column. (6,8)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h7F, 40'hFF_FFFF_FFFF, 1'b0, 1'b0},
        // Narrow panel with wrap off.
        '{ROW_REG, tcr_pkg::REG_PANEL_WIDTH, 16'd20, 8'h0, 40'h0, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_WRAP_ENABLE, 16'd0, 8'h0, 40'h0, 1'b0, 1'b0},
        // Still fits inside the panel. (12,8)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h42, 40'h10_08_04_02_01, 1'b0, 1'b0},
        // Cut at the right edge. (18,8)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h43, 40'hC3_66_3C_18_81, 1'b0, 1'b0},
        // Starts past the right edge and is dropped. (24,8)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h44, 40'hFF_FFFF_FFFF, 1'b0, 1'b1},
        '{ROW_REG, tcr_pkg::REG_WRAP_ENABLE, 16'd1, 8'h0, 40'h0, 1'b0, 1'b0},
        // Wraps to (0,16) before drawing. (30,8)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h45, 40'h7F_49_49_49_36, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_PANEL_HEIGHT, 16'd20, 8'h0, 40'h0, 1'b0, 1'b0},
        // Cut at the bottom edge, short background column. (6,16)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h46, 40'hFF_FFFF_FFFF, 1'b0, 1'b0},
        // Newline to (0,24), below the panel.
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, tcr_pkg::CH_NEWLINE, 40'h0, 1'b0, 1'b0},
        // Starts below the bottom edge and is dropped. (0,24)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h47, 40'hFF_FFFF_FFFF, 1'b0, 1'b1},
        '{ROW_REG, tcr_pkg::REG_PANEL_HEIGHT, 16'd1024, 8'h0, 40'h0, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_TEXT_SIZE, 16'd2, 8'h0, 40'h0, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_PANEL_WIDTH, 16'd1, 8'h0, 40'h0, 1'b0, 1'b0},
        // Cell wider than a one pixel panel: wraps, then nothing fits. (6,24)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h48, 40'hFF_FFFF_FFFF, 1'b1, 1'b1},
        '{ROW_REG, tcr_pkg::REG_PANEL_WIDTH, 16'd1024, 8'h0, 40'h0, 1'b0, 1'b0},
        // Double scale on the widest panel. (12,40)
        '{ROW_CHAR, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h80, 40'h80_40_20_10_08, 1'b0, 1'b0},
        '{ROW_REG, tcr_pkg::REG_PANEL_HEIGHT, 16'd1, 8'h0, 40'h0, 1'b0, 1'b0},
        // One row high panel: the cell starts below it and is dropped. (24,40)
        '{ROW_EMPTY, tcr_pkg::REG_TEXT_SIZE, 16'h0, 8'h49, 40'hFF_FFFF_FFFF, 1'b0, 1'b1},
        '{ROW_REG, tcr_pkg::REG_PANEL_HEIGHT, 16'd1024, 8'h0, 40'h0, 1'b0, 1'b0}
    };

    logic        clk;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h0;
    logic [39:0] glyph_columns = 40'h0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        block_valid;
    logic [14:0] block_x;
    logic [14:0] block_y;
    logic [7:0]  block_w;
    logic [10:0] block_h;
    logic [15:0] block_color;
    logic        wrapped;
    logic        clipped;
    logic        last;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'h0;

    // Shadow copy of the registers, at their reset values.
    logic [7:0]  size_reg = 8'd1;
    logic [15:0] fg_reg = 16'hFFFF;
    logic [15:0] bg_reg = 16'hFFFF;
    logic        wrap_reg = 1'b1;
    logic [10:0] width_reg = 11'd368;
    logic [10:0] height_reg = 11'd448;

    // Predicted text cursor.
    int pen_col = 0;
    int pen_row = 0;

    // Fill blocks predicted for the character in hand, and every fill block
    // word still owed by the block, oldest first.
    tcr_pkg::result_t char_blocks [$];
    tcr_pkg::result_t pending_blocks [$];

    int  err_count = 0;
    int  idle_pct = 10;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    text_cell_rasterizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .glyph_columns (glyph_columns),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .block_valid   (block_valid),
        .block_x       (block_x),
        .block_y       (block_y),
        .block_w       (block_w),
        .block_h       (block_h),
        .block_color   (block_color),
        .wrapped       (wrapped),
        .clipped       (clipped),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic int sat_coord(input int v);
        return (v > tcr_pkg::COORD_MAX) ? tcr_pkg::COORD_MAX : v;
    endfunction

    // The word sent when nothing is drawn: only the flags and last are set.
    function automatic tcr_pkg::result_t empty_word(input logic wr, input logic cl);
        tcr_pkg::result_t r;
        r = '0;
        r.wrapped = wr;
        r.clipped = cl;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic tcr_pkg::result_t fill_block(input int bx, input int by, input int bw,
                                                    input int bh, input logic [15:0] color,
                                                    input logic wr, input logic cl);
        tcr_pkg::result_t r;
        r = '0;
        r.block_valid = 1'b1;
        r.block_x = 15'(bx);
        r.block_y = 15'(by);
        r.block_w = 8'(bw);
        r.block_h = 11'(bh);
        r.block_color = color;
        r.wrapped = wr;
        r.clipped = cl;
        return r;
    endfunction

    // Works out the fill blocks of one character into char_blocks and moves the
    // predicted cursor. Glyph columns go left to right, rows top to bottom within
    // a column, and the background column comes last.
    function automatic void rasterize_char(input logic [7:0] code, input logic [39:0] glyph);
        int s;
        int max_x;
        int max_y;
        int cw;
        int chh;
        int x;
        int y;
        int cx;
        int cy;
        int h;
        int i;
        int j;
        logic wr;
        logic cl;
        logic transparent;
        logic [7:0] line;

        char_blocks.delete();
        s = (size_reg == 8'd0) ? 1 : int'(size_reg);
        max_x = int'(width_reg) - 1;
        max_y = int'(height_reg) - 1;
        cw = (tcr_pkg::GLYPH_COLUMNS_DEF + 1) * s;
        chh = tcr_pkg::CELL_ROWS * s;
        wr = 1'b0;
        cl = 1'b0;
        transparent = (fg_reg == bg_reg);

        if (code == tcr_pkg::CH_NEWLINE)
        begin
            pen_col = 0;
            pen_row = sat_coord(pen_row + chh);
            char_blocks = {char_blocks, empty_word(1'b0, 1'b0)};
            return;
        end
        if (code == tcr_pkg::CH_RETURN)
        begin
            char_blocks = {char_blocks, empty_word(1'b0, 1'b0)};
            return;
        end

        if (wrap_reg && (pen_col + cw - 1 > max_x))
        begin
            pen_col = 0;
            pen_row = sat_coord(pen_row + chh);
            wr = 1'b1;
        end
        x = pen_col;
        y = pen_row;

        if (x > max_x || y > max_y)
        begin
            cl = 1'b1;
        end
        else
        begin
            if ((x + cw - 1 > max_x) || (y + chh - 1 > max_y))
                cl = 1'b1;
            for (i = 0; i < tcr_pkg::GLYPH_COLUMNS_DEF; i++)
            begin
                cx = x + i * s;
                if (cx + s - 1 > max_x)
                    continue;
                // Only five column bytes arrive, so any column past them reads as zero.
                line = (i < tcr_pkg::FONT_BYTES) ? glyph[8 * i +: 8] : 8'h00;
                for (j = 0; j < tcr_pkg::CELL_ROWS; j++)
                begin
                    cy = y + j * s;
                    if (cy + s - 1 > max_y)
                        continue;
                    if (!line[j] && transparent)
                        continue;
                    char_blocks = {char_blocks,
                                   fill_block(cx, cy, s, s, line[j] ? fg_reg : bg_reg,
                                              wr, cl)};
                end
            end
            if (!transparent)
            begin
                cx = x + tcr_pkg::GLYPH_COLUMNS_DEF * s;
                if (cx + s - 1 <= max_x)
                begin
                    h = max_y - y + 1;
                    if (h > chh)
                        h = chh;
                    char_blocks = {char_blocks, fill_block(cx, y, s, h, bg_reg, wr, cl)};
                end
            end
        end

        if (char_blocks.size() == 0)
            char_blocks = {char_blocks, empty_word(wr, cl)};
        char_blocks[char_blocks.size() - 1].last = 1'b1;
        pen_col = sat_coord(pen_col + cw);
    endfunction

    // Every character yields at least one word, so an empty queue plus a short
    // gap means the block has gone back to idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input tcr_pkg::reg_idx_t idx, input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tcr_pkg::REG_TEXT_SIZE:    size_reg = value[7:0];
            tcr_pkg::REG_TEXT_COLOR:   fg_reg = value;
            tcr_pkg::REG_BACK_COLOR:   bg_reg = value;
            tcr_pkg::REG_WRAP_ENABLE:  wrap_reg = value[0];
            tcr_pkg::REG_PANEL_WIDTH:  width_reg = value[10:0];
            tcr_pkg::REG_PANEL_HEIGHT: height_reg = value[10:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offers one character word and, once it is taken, queues its expected fill
    // blocks. A typed row replaces the prediction with its known empty word, but
    // the predictor still runs so that the cursor stays in step.
    task automatic send_char(input logic [7:0] code, input logic [39:0] glyph,
                             input bit typed, input logic wr, input logic cl);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= code;
        glyph_columns <= glyph;
        do
            @(posedge clk);
        while (in_stall);
        rasterize_char(code, glyph);
        if (typed)
            pending_blocks = {pending_blocks, empty_word(wr, cl)};
        else
            pending_blocks = {pending_blocks, char_blocks};
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Result checker: every word taken from the output is compared, field by
    // field, with the oldest fill block still owed.
    always @(posedge clk)
    begin
        tcr_pkg::result_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("Fill block word arrived with none expected");
                err_count++;
            end
            else
            begin
                exp_w = pending_blocks.pop_front();
                check_field("block_valid", 16'(exp_w.block_valid), 16'(block_valid));
                check_field("block_x", 16'(exp_w.block_x), 16'(block_x));
                check_field("block_y", 16'(exp_w.block_y), 16'(block_y));
                check_field("block_w", 16'(exp_w.block_w), 16'(block_w));
                check_field("block_h", 16'(exp_w.block_h), 16'(block_h));
                check_field("block_color", exp_w.block_color, block_color);
                check_field("wrapped", 16'(exp_w.wrapped), 16'(wrapped));
                check_field("clipped", 16'(exp_w.clipped), 16'(clipped));
                check_field("last", 16'(exp_w.last), 16'(last));
            end
        end
    end

    // Output back-pressure. Normally the receiver stalls at random; once, on
    // request, it holds off for a long stretch so that the block fills up and
    // stalls the character input behind it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    row;
        int          k;
        int          phase;
        int          pick;
        int          rows_h;
        logic [7:0]  code;
        logic [39:0] glyph;
        logic [15:0] color;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the register defaults first, then the edges of the panel.
        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            row = DIRECTED[k];
            case (row.kind)
                ROW_REG:   write_reg(row.idx, row.value);
                ROW_CHAR:  send_char(row.code, row.glyph, 1'b0, 1'b0, 1'b0);
                ROW_EMPTY: send_char(row.code, row.glyph, 1'b1, row.wr, row.cl);
                default: ;
            endcase
        end

        // Random phases. The cursor row only ever grows, so scales stay small here
        // to keep most characters on the panel; some phases pull the bottom edge up
        // just below the cursor to exercise bottom clipping and drops. Phase one
        // runs with no idling on either side, and phase three holds the output off.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_pct = (phase == 1) ? 0 : 10;
            color = 16'($urandom_range(0, 65535));
            write_reg(tcr_pkg::REG_TEXT_SIZE, 16'($urandom_range(1, 3)));
            write_reg(tcr_pkg::REG_TEXT_COLOR, color);
            // Roughly one phase in four is transparent.
            if ($urandom_range(3) == 0)
                write_reg(tcr_pkg::REG_BACK_COLOR, color);
            else
                write_reg(tcr_pkg::REG_BACK_COLOR, 16'($urandom_range(0, 65535)));
            write_reg(tcr_pkg::REG_WRAP_ENABLE, 16'($urandom_range(99) < 70));
            write_reg(tcr_pkg::REG_PANEL_WIDTH, 16'($urandom_range(300, 1024)));
            rows_h = 1024;
            if (phase % 3 == 1)
            begin
                rows_h = pen_row + $urandom_range(1, 48);
                if (rows_h > 1024)
                    rows_h = 1024;
            end
            write_reg(tcr_pkg::REG_PANEL_HEIGHT, 16'(rows_h));

            for (k = 0; k < PHASE_CHARS; k++)
            begin
                if (phase == 3 && k == 5)
                    hold_req = 1'b1;
                pick = $urandom_range(99);
                if (pick < 5)
                    code = tcr_pkg::CH_NEWLINE;
                else if (pick < 8)
                    code = tcr_pkg::CH_RETURN;
                else
                    code = 8'($urandom_range(0, 255));
                pick = $urandom_range(99);
                if (pick < 10)
                    glyph = 40'h0;
                else if (pick < 20)
                    glyph = 40'hFF_FFFF_FFFF;
                else
                    glyph = 40'({$urandom(), $urandom()});
                send_char(code, glyph, 1'b0, 1'b0, 1'b0);
            end
        end

        // Largest scale: with wrap off the column runs into saturation, then a run
        // of newlines saturates the row, and with wrap back on every character
        // wraps at the saturated row and is dropped.
        idle_pct = 10;
        write_reg(tcr_pkg::REG_TEXT_SIZE, 16'd255);
        write_reg(tcr_pkg::REG_WRAP_ENABLE, 16'd0);
        write_reg(tcr_pkg::REG_TEXT_COLOR, 16'hFFFF);
        write_reg(tcr_pkg::REG_BACK_COLOR, 16'h0000);
        write_reg(tcr_pkg::REG_PANEL_WIDTH, 16'd1024);
        write_reg(tcr_pkg::REG_PANEL_HEIGHT, 16'd1024);
        for (k = 0; k < 24; k++)
            send_char(8'(8'h41 + k), 40'({$urandom(), $urandom()}), 1'b0, 1'b0, 1'b0);
        for (k = 0; k < 18; k++)
            send_char(tcr_pkg::CH_NEWLINE, 40'({$urandom(), $urandom()}), 1'b0, 1'b0, 1'b0);
        write_reg(tcr_pkg::REG_WRAP_ENABLE, 16'd1);
        for (k = 0; k < 8; k++)
            send_char(8'($urandom_range(0, 255)), 40'({$urandom(), $urandom()}),
                      1'b0, 1'b0, 1'b0);

        // Drain: wait for every owed word, then a little longer to catch strays.
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (END_GAP) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
